>>> rtl/tbpc_pkg.sv
// Shared types, constants and register indexes of the two-button press classifier.
package tbpc_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CodeW = 2;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [CntW-1:0] DebounceReset = 16'd50;
  localparam logic [CntW-1:0] LongReset = 16'd2000;
  localparam logic [CntW-1:0] CancelReset = 16'd11000;

  localparam logic [CfgIdxW-1:0] CfgDebounce = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLong = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCancel = 2'd2;

  localparam logic [CodeW-1:0] CodeCancel = 2'd0;
  localparam logic [CodeW-1:0] CodeA = 2'd1;
  localparam logic [CodeW-1:0] CodeB = 2'd2;
  localparam logic [CodeW-1:0] CodeLong = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HOLD     = 2'd2
  } phase_e;

  typedef struct packed {
    logic button_a;
    logic button_b;
    logic buffer_busy;
    logic state_busy;
  } tick_t;

endpackage

>>> rtl/tbpc_if.sv
// Valid/ready channel interfaces for the tick input and the press code output.
interface tbpc_in_if;
  logic valid;
  logic ready;
  logic button_a;
  logic button_b;
  logic buffer_busy;
  logic state_busy;

  modport source (output valid, output button_a, output button_b,
                  output buffer_busy, output state_busy, input ready);
  modport sink (input valid, input button_a, input button_b,
                input buffer_busy, input state_busy, output ready);
endinterface

interface tbpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_code;

  modport source (output valid, output press_code, input ready);
  modport sink (input valid, input press_code, output ready);
endinterface

>>> rtl/tbpc_in_stage.sv
// Input register that holds one tick beat until the classifier takes it.
module tbpc_in_stage import tbpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  tick_t in_tick_i,
  output logic  tick_valid_o,
  output tick_t tick_o,
  input  logic  tick_take_i
);

  logic  valid_q, valid_d;
  tick_t tick_q;

  assign in_ready_o = !valid_q || tick_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (tick_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tick_q <= in_tick_i;
    end
  end

  assign tick_valid_o = valid_q;
  assign tick_o       = tick_q;

endmodule

>>> rtl/tbpc_core.sv
// Press classification state, timing registers and the press code output register.
module tbpc_core import tbpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CntW-1:0]    cfg_data_i,
  input  logic               tick_valid_i,
  input  tick_t              tick_i,
  output logic               tick_take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CodeW-1:0]   out_code_o
);

  logic [CntW-1:0]  deb_ticks_q, long_ticks_q, cancel_ticks_q;
  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  deb_cnt_q, deb_cnt_d;
  logic [CntW-1:0]  hold_cnt_q, hold_cnt_d;
  logic [CodeW-1:0] pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  logic [CodeW-1:0] code_q, code_d;

  logic             pressed, busy;
  logic             emit;
  logic [CodeW-1:0] emit_code;
  logic [CntW-1:0]  deb_inc, hold_inc;
  logic [CodeW-1:0] accept_code;

  assign tick_take_o = tick_valid_i && (!out_valid_q || out_ready_i);

  assign pressed     = tick_i.button_a || tick_i.button_b;
  assign busy        = tick_i.buffer_busy || tick_i.state_busy;
  assign accept_code = tick_i.button_a ? CodeA : CodeB;
  assign deb_inc     = (deb_cnt_q == CntMax) ? deb_cnt_q : deb_cnt_q + 1'b1;
  assign hold_inc    = (hold_cnt_q == CntMax) ? hold_cnt_q : hold_cnt_q + 1'b1;

  // Next state of the classifier for the tick now in the input register.
  always_comb begin
    phase_d    = phase_q;
    deb_cnt_d  = deb_cnt_q;
    hold_cnt_d = hold_cnt_q;
    pend_d     = pend_q;
    emit       = 1'b0;
    emit_code  = CodeCancel;
    if (busy) begin
      // An abandoned hold reports its code unless both flags are up.
      if (phase_q == PH_HOLD) begin
        emit      = 1'b1;
        emit_code = (tick_i.buffer_busy && tick_i.state_busy) ? CodeCancel : pend_q;
      end
      phase_d    = PH_IDLE;
      deb_cnt_d  = '0;
      hold_cnt_d = '0;
    end else begin
      case (phase_q)
        PH_DEBOUNCE: begin
          if (!pressed) begin
            phase_d    = PH_IDLE;
            deb_cnt_d  = '0;
            hold_cnt_d = '0;
          end else if (deb_inc >= deb_ticks_q) begin
            phase_d    = PH_HOLD;
            pend_d     = accept_code;
            deb_cnt_d  = '0;
            hold_cnt_d = '0;
          end else begin
            deb_cnt_d = deb_inc;
          end
        end
        PH_HOLD: begin
          if (!pressed) begin
            emit       = 1'b1;
            emit_code  = pend_q;
            phase_d    = PH_IDLE;
            deb_cnt_d  = '0;
            hold_cnt_d = '0;
          end else if (hold_inc >= cancel_ticks_q) begin
            emit       = 1'b1;
            emit_code  = CodeCancel;
            phase_d    = PH_IDLE;
            deb_cnt_d  = '0;
            hold_cnt_d = '0;
          end else begin
            hold_cnt_d = hold_inc;
            if (hold_inc >= long_ticks_q) begin
              pend_d = CodeLong;
            end
          end
        end
        default: begin
          // Idle: a debounce time of zero or one accepts on the first pressed tick.
          phase_d    = PH_IDLE;
          deb_cnt_d  = '0;
          hold_cnt_d = '0;
          if (pressed) begin
            if (deb_ticks_q <= CntW'(1)) begin
              phase_d = PH_HOLD;
              pend_d  = accept_code;
            end else begin
              phase_d   = PH_DEBOUNCE;
              deb_cnt_d = CntW'(1);
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    code_d      = code_q;
    if (tick_take_o && emit) begin
      out_valid_d = 1'b1;
      code_d      = emit_code;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q    <= DebounceReset;
      long_ticks_q   <= LongReset;
      cancel_ticks_q <= CancelReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDebounce: deb_ticks_q    <= cfg_data_i;
        CfgLong:     long_ticks_q   <= cfg_data_i;
        CfgCancel:   cancel_ticks_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      deb_cnt_q   <= '0;
      hold_cnt_q  <= '0;
      pend_q      <= CodeCancel;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_take_o) begin
        phase_q    <= phase_d;
        deb_cnt_q  <= deb_cnt_d;
        hold_cnt_q <= hold_cnt_d;
        pend_q     <= pend_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = code_q;

endmodule

>>> rtl/two_button_press_classifier_top.sv
// Top level of the two-button press classifier: input register, classifier core.
// A tick beat passes through the input register, and any press code it gives is held in the output register.
// Throughput: one tick beat per cycle unless an unread code stalls it; the classifier state updates once per beat.
// The input register and the output register let a new beat enter while a code waits.
// Reset (rst_ni low, asynchronous) empties both registers, returns to idle with cleared
// counters and loads debounce 50, long press 2000 and cancel 11000 ticks.
module two_button_press_classifier_top import tbpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CntW-1:0]    cfg_data_i,
  tbpc_in_if.sink            in_i,
  tbpc_out_if.source         out_o
);

  tick_t in_tick, tick;
  logic  tick_valid, tick_take;

  assign in_tick.button_a    = in_i.button_a;
  assign in_tick.button_b    = in_i.button_b;
  assign in_tick.buffer_busy = in_i.buffer_busy;
  assign in_tick.state_busy  = in_i.state_busy;

  tbpc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_tick_i    (in_tick),
    .tick_valid_o (tick_valid),
    .tick_o       (tick),
    .tick_take_i  (tick_take)
  );

  tbpc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .tick_valid_i (tick_valid),
    .tick_i       (tick),
    .tick_take_o  (tick_take),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_code_o   (out_o.press_code)
  );

endmodule

>>> dv/tb_two_button_press_classifier_top.sv
`timescale 1ns / 100ps
// Testbench of the two-button press classifier: tick streams checked against a timing predictor.
module tb_two_button_press_classifier_top;
  import tbpc_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned TicksPerPhase = 100;

  // Tracks the classifier state per accepted tick and holds the press codes still due.
  class press_code_tracker;
    logic [CntW-1:0]  debounce_ticks;
    logic [CntW-1:0]  long_ticks;
    logic [CntW-1:0]  cancel_ticks;
    phase_e           phase;
    logic [CntW-1:0]  debounce_cnt;
    logic [CntW-1:0]  hold_cnt;
    logic [CodeW-1:0] pending_code;
    logic [CodeW-1:0] due_codes[$];
    int unsigned      failures;

    function new();
      debounce_ticks = DebounceReset;
      long_ticks = LongReset;
      cancel_ticks = CancelReset;
      pending_code = CodeCancel;
      failures = 0;
      rearm();
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] value);
      case (idx)
        CfgDebounce: debounce_ticks = value;
        CfgLong: long_ticks = value;
        CfgCancel: cancel_ticks = value;
        default: ;
      endcase
    endfunction

    function void rearm();
      phase = PH_IDLE;
      debounce_cnt = '0;
      hold_cnt = '0;
    endfunction

    function void accept(logic button_a);
      pending_code = button_a ? CodeA : CodeB;
      debounce_cnt = '0;
      hold_cnt = '0;
      phase = PH_HOLD;
    endfunction

    function void classify_tick(tick_t t);
      logic pressed;
      pressed = t.button_a | t.button_b;
      if (t.buffer_busy | t.state_busy) begin
        // An abandoned hold reports its code, unless both systems are busy.
        if (phase == PH_HOLD)
          due_codes.push_back((t.buffer_busy & t.state_busy) ? CodeCancel : pending_code);
        rearm();
      end else begin
        case (phase)
          PH_IDLE: begin
            if (pressed) begin
              if (debounce_ticks <= 1) begin
                accept(t.button_a);
              end else begin
                phase = PH_DEBOUNCE;
                debounce_cnt = CntW'(1);
              end
            end
          end
          PH_DEBOUNCE: begin
            if (!pressed) begin
              rearm();
            end else begin
              if (debounce_cnt != CntMax) debounce_cnt++;
              if (debounce_cnt >= debounce_ticks) accept(t.button_a);
            end
          end
          default: begin
            if (!pressed) begin
              due_codes.push_back(pending_code);
              rearm();
            end else begin
              if (hold_cnt != CntMax) hold_cnt++;
              // Cancel is checked first, so it wins when it is not above the long time.
              if (hold_cnt >= cancel_ticks) begin
                due_codes.push_back(CodeCancel);
                rearm();
              end else if (hold_cnt >= long_ticks) begin
                pending_code = CodeLong;
              end
            end
          end
        endcase
      end
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= MaxReported) $display("%s", msg);
    endfunction

    function void check_press_code(logic [CodeW-1:0] got);
      logic [CodeW-1:0] want;
      if (due_codes.size() == 0) begin
        note_failure($sformatf("press code %0d arrived with none expected", got));
      end else begin
        want = due_codes.pop_front();
        if (got !== want)
          note_failure($sformatf("press code mismatch: expected %0d, got %0d", want, got));
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CntW-1:0]    cfg_data;

  logic [CntW-1:0]    cur_db;
  logic [CntW-1:0]    cur_lp;
  logic [CntW-1:0]    cur_cn;
  bit                 allow_gaps;
  bit                 hold_req;
  int unsigned        burst_left;
  int unsigned        ticks_sent;

  press_code_tracker tracker = new();

  tbpc_in_if  tick_if ();
  tbpc_out_if code_if ();

  two_button_press_classifier_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (tick_if),
    .out_o      (code_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb_two_button_press_classifier_top: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (tick_if.valid && tick_if.ready)
        tracker.classify_tick(tick_t'({tick_if.button_a, tick_if.button_b,
                                       tick_if.buffer_busy, tick_if.state_busy}));
      if (code_if.valid && code_if.ready)
        tracker.check_press_code(code_if.press_code);
    end
  end

  // The code receiver stalls on patterns of its own, and once for a long stretch on request.
  initial begin : code_receiver
    int unsigned mode;
    int unsigned span;
    code_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        code_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 150);
        for (int unsigned i = 0; i < span && !hold_req; i++) begin
          case (mode)
            0: code_if.ready <= 1'b1;
            1: code_if.ready <= 1'($urandom_range(0, 1));
            2: code_if.ready <= ($urandom_range(0, 4) == 0);
            default: code_if.ready <= (i % 4 != 3);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_tick(input logic a, input logic b, input logic bb, input logic sb);
    tick_if.valid <= 1'b1;
    tick_if.button_a <= a;
    tick_if.button_b <= b;
    tick_if.buffer_busy <= bb;
    tick_if.state_busy <= sb;
    do @(posedge clk); while (tick_if.ready !== 1'b1);
    ticks_sent++;
    if (allow_gaps) begin
      if (burst_left == 0) begin
        tick_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 250)
                                                 : $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic hold_levels(input logic a, input logic b, input int unsigned n);
    repeat (n) send_tick(a, b, 1'b0, 1'b0);
  endtask

  // Waits until every due code has come out and the pipeline has run empty.
  // The first edge lets the monitor note the last beat before the queue is looked at.
  task automatic settle();
    tick_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_codes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_timing(input logic [CntW-1:0] d, input logic [CntW-1:0] l,
                                input logic [CntW-1:0] c);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= CfgDebounce;
    cfg_data <= d;
    @(posedge clk);
    cfg_idx <= CfgLong;
    cfg_data <= l;
    @(posedge clk);
    cfg_idx <= CfgCancel;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_register(CfgDebounce, d);
    tracker.write_register(CfgLong, l);
    tracker.write_register(CfgCancel, c);
    cur_db = d;
    cur_lp = l;
    cur_cn = c;
  endtask

  // A press of random length and buttons, with the odd button change or busy beat.
  task automatic random_press();
    int unsigned lead;
    int unsigned span;
    int unsigned hi;
    int unsigned combo;
    logic [1:0]  busy;
    lead = $urandom_range(0, 3);
    repeat (lead) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    combo = $urandom_range(1, 3);
    hi = cur_db + ((cur_cn > cur_lp) ? cur_cn : cur_lp) + 2;
    if (hi > 60) hi = 60;
    span = $urandom_range(1, hi);
    repeat (span) begin
      if ($urandom_range(0, 7) == 0) combo = $urandom_range(1, 3);
      if ($urandom_range(0, 24) == 0) begin
        busy = 2'($urandom_range(1, 3));
        send_tick(combo[0], combo[1], busy[1], busy[0]);
      end else begin
        send_tick(combo[0], combo[1], 1'b0, 1'b0);
      end
    end
    busy = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
    send_tick(1'b0, 1'b0, busy[1], busy[0]);
  endtask

  task automatic noise(input int unsigned n);
    logic [3:0] r;
    repeat (n) begin
      r = 4'($urandom_range(0, 15));
      send_tick(r[3], r[2], r[1], r[0]);
    end
  endtask

  task automatic random_phase(input logic [CntW-1:0] d, input logic [CntW-1:0] l,
                              input logic [CntW-1:0] c, input bit squeeze);
    int unsigned start;
    program_timing(d, l, c);
    if (squeeze) hold_req = 1'b1;
    start = ticks_sent;
    while (ticks_sent - start < TicksPerPhase) begin
      if ($urandom_range(0, 4) != 0) random_press();
      else noise($urandom_range(1, 6));
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgDebounce;
    cfg_data = '0;
    tick_if.valid = 1'b0;
    tick_if.button_a = 1'b0;
    tick_if.button_b = 1'b0;
    tick_if.buffer_busy = 1'b0;
    tick_if.state_busy = 1'b0;
    cur_db = DebounceReset;
    cur_lp = LongReset;
    cur_cn = CancelReset;
    allow_gaps = 1'b0;
    hold_req = 1'b0;
    burst_left = 0;
    ticks_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timing: a short press that passes the default debounce time.
    hold_levels(1'b1, 1'b0, 60);
    hold_levels(1'b0, 1'b0, 2);

    allow_gaps = 1'b1;
    program_timing(16'd2, 16'd3, 16'd5);
    hold_levels(1'b1, 1'b0, 1);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    hold_levels(1'b1, 1'b0, 2);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    hold_levels(1'b0, 1'b1, 2);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    hold_levels(1'b1, 1'b1, 2);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b1);
    hold_levels(1'b0, 1'b1, 1);
    send_tick(1'b0, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    hold_levels(1'b1, 1'b0, 2);
    send_tick(1'b1, 1'b0, 1'b1, 1'b0);
    hold_levels(1'b0, 1'b1, 3);
    send_tick(1'b1, 1'b1, 1'b0, 1'b1);
    hold_levels(1'b1, 1'b1, 2);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1);
    hold_levels(1'b1, 1'b1, 5);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    // After the cancel the button stays down one more tick and starts a fresh debounce.
    hold_levels(1'b1, 1'b0, 8);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);

    random_phase(16'd0, 16'd0, 16'd0, 1'b0);
    random_phase(16'd0, 16'd5, 16'd3, 1'b0);
    random_phase(16'd1, 16'd0, 16'd6, 1'b0);
    random_phase(16'd0, 16'd2, 16'd4, 1'b1);
    random_phase(CntMax, CntMax, CntMax, 1'b0);
    random_phase(16'd3, CntMax, 16'd20, 1'b0);
    random_phase(CntW'($urandom_range(0, 65535)), CntW'($urandom_range(0, 65535)),
                 CntW'($urandom_range(0, 65535)), 1'b0);
    repeat (3)
      random_phase(CntW'($urandom_range(0, 4)), CntW'($urandom_range(0, 10)),
                   CntW'($urandom_range(0, 14)), 1'b0);

    settle();
    if (tracker.failures == 0) begin
      $display("tb_two_button_press_classifier_top: PASS");
    end else begin
      $display("tb_two_button_press_classifier_top: FAIL");
    end
    $finish;
  end

endmodule
